### hw/rtl/ptts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_pkg: periodic task tick scheduler shared types
// Transaction structs, function and result-kind codes, cell broadcast bundle.
// ----------------------------------------------------------------------------
package ptts_pkg;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_ADD  = 1'b1;

  localparam logic [1:0] KIND_FIRE = 2'd0;
  localparam logic [1:0] KIND_ADD  = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic        func;
    logic [15:0] period;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  task_index;
    logic        status;
    logic [31:0] time_now;
    logic        last;
  } res_t;

  // Shared by every cell of the chain each cycle
  typedef struct packed {
    logic [31:0] now;
    logic [15:0] period;
  } cell_bcast_t;

endpackage

### hw/rtl/ptts_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_cell: one task slot of the scheduler chain
// Holds period, deadline and active flag; checks its deadline when the scan
// token passes through, then hands the token to the next cell.
// ----------------------------------------------------------------------------
module ptts_cell import ptts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cell_bcast_t bcast,
  input  logic        wr_en,
  input  logic        tok_in,
  output logic        tok_out,
  output logic        fire
);

  logic        tok;
  logic        active;
  logic [15:0] period;
  logic [31:0] deadline;

  assign tok_out = tok;
  assign fire    = tok && active && (bcast.now > deadline);

  always_ff @(posedge clk) begin
    if (rst) begin
      tok    <= 1'b0;
      active <= 1'b0;
    end else begin
      tok <= tok_in;
      if (wr_en) begin
        active <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      period   <= bcast.period;
      deadline <= bcast.now + {16'd0, bcast.period};
    end else if (fire) begin
      deadline <= bcast.now + {16'd0, period};
    end
  end

endmodule

### hw/rtl/periodic_task_tick_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler_unit: periodic task table with tick counter
// Add-task fills the next free slot; a tick scans all slots through a chain
// of cells, reports each due task, then advances time and reports done.
// ----------------------------------------------------------------------------
// Add-task: result strobed in the cycle after the transaction; busy stays low.
// Tick: busy until the done result is strobed, so a new tick waits for the scan to end;
//   the token walks one cell per cycle, each due slot is reported in slot order, then done.
// Results are strobed for one cycle; the receiver cannot stall them.
// Synchronous reset clears time, slot count, all active flags and the token.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler_unit import ptts_pkg::*; #(
  parameter int unsigned TASK_SLOTS = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  cmd_t cmd,
  output logic busy,
  output logic res_strobe,
  output res_t res
);

  localparam int unsigned CW = $clog2(TASK_SLOTS + 1);

  logic [31:0]           tick_count;
  logic [CW-1:0]         slots_used;
  logic                  done_pend;
  logic                  accept;
  logic                  add_ok;
  cell_bcast_t           bcast;
  logic [TASK_SLOTS-1:0] wr_sel;
  logic [TASK_SLOTS:0]   tok;       // tok[i] enters cell i; tok[TASK_SLOTS] leaves the chain
  logic [TASK_SLOTS-1:0] fire;
  logic                  any_fire;
  logic [5:0]            fire_idx;
  logic [31:0]           after;

  assign accept = start && !busy;
  assign add_ok = slots_used < CW'(TASK_SLOTS);
  assign after  = tick_count + 32'd1;

  // Time and period go to every cell; only the selected cell writes.
  assign bcast.now    = tick_count;
  assign bcast.period = cmd.period;

  // Token enters cell 0 on a tick transaction
  assign tok[0] = accept && (cmd.func == FUNC_TICK);

  always_comb begin
    for (int i = 0; i < TASK_SLOTS; i++) begin
      wr_sel[i] = accept && (cmd.func == FUNC_ADD) && add_ok && (slots_used == CW'(i));
    end
  end

  genvar g;
  generate
    for (g = 0; g < TASK_SLOTS; g++) begin : g_cell
      ptts_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .bcast   (bcast),
        .wr_en   (wr_sel[g]),
        .tok_in  (tok[g]),
        .tok_out (tok[g+1]),
        .fire    (fire[g])
      );
    end
  endgenerate

  // At most one cell holds the token, so fire is one-hot or zero.
  always_comb begin
    fire_idx = '0;
    for (int i = 0; i < TASK_SLOTS; i++) begin
      fire_idx = fire_idx | (fire[i] ? 6'(i) : 6'd0);
    end
  end
  assign any_fire = |fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      slots_used <= '0;
      busy       <= 1'b0;
      done_pend  <= 1'b0;
      res_strobe <= 1'b0;
    end else begin
      res_strobe <= 1'b0;
      done_pend  <= tok[TASK_SLOTS];

      if (accept && (cmd.func == FUNC_TICK)) begin
        busy <= 1'b1;
      end

      if (accept && (cmd.func == FUNC_ADD)) begin
        // Add answer: counter unchanged
        res_strobe     <= 1'b1;
        res.kind       <= KIND_ADD;
        res.task_index <= add_ok ? 6'(slots_used) : 6'd0;
        res.status     <= add_ok ? STATUS_OK : STATUS_FULL;
        res.time_now   <= tick_count;
        res.last       <= 1'b1;
        if (add_ok) begin
          slots_used <= slots_used + CW'(1);
        end
      end else if (any_fire) begin
        res_strobe     <= 1'b1;
        res.kind       <= KIND_FIRE;
        res.task_index <= fire_idx;
        res.status     <= STATUS_OK;
        res.time_now   <= after;
        res.last       <= 1'b0;
      end else if (done_pend) begin
        // Scan finished: close the run and advance time
        res_strobe     <= 1'b1;
        res.kind       <= KIND_DONE;
        res.task_index <= 6'd0;
        res.status     <= STATUS_OK;
        res.time_now   <= after;
        res.last       <= 1'b1;
        tick_count     <= after;
        busy           <= 1'b0;
      end
    end
  end

endmodule

### tb/ptts_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_scoreboard: schedule predictor and result checker
// Tracks every accepted command, predicts the fire, add and done results it
// causes, and compares each strobed result against the oldest prediction.
// ----------------------------------------------------------------------------
module ptts_scoreboard import ptts_pkg::*; #(
  parameter int unsigned TASK_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  cmd_t        cmd,
  input  logic        res_strobe,
  input  res_t        res,
  output int unsigned fail_count,
  output int unsigned open_count
);

  // Shadow of the task table
  logic [31:0] tick_now;
  logic [15:0] slot_per [TASK_SLOTS];
  logic [31:0] slot_due [TASK_SLOTS];
  logic        slot_on  [TASK_SLOTS];
  int unsigned slots_taken;

  res_t pending_events[$];

  task automatic clear_table();
    tick_now    = '0;
    slots_taken = 0;
    for (int i = 0; i < TASK_SLOTS; i++) begin
      slot_per[i] = '0;
      slot_due[i] = '0;
      slot_on[i]  = 1'b0;
    end
    pending_events.delete();
  endtask

  // Advance the shadow table by one command and queue what it must report
  task automatic advance_schedule(cmd_t c);
    res_t        r;
    logic [31:0] after;
    r = '0;
    if (c.func == FUNC_ADD) begin
      r.kind     = KIND_ADD;
      r.time_now = tick_now;
      r.last     = 1'b1;
      if (slots_taken < TASK_SLOTS) begin
        slot_per[slots_taken] = c.period;
        slot_due[slots_taken] = tick_now + 32'(c.period);
        slot_on[slots_taken]  = 1'b1;
        r.task_index          = 6'(slots_taken);
        r.status              = STATUS_OK;
        slots_taken++;
      end else begin
        r.status = STATUS_FULL;
      end
      pending_events.push_back(r);
    end else begin
      after = tick_now + 32'd1;
      for (int i = 0; i < TASK_SLOTS; i++) begin
        if (slot_on[i] && tick_now > slot_due[i]) begin
          slot_due[i]  = tick_now + 32'(slot_per[i]);
          r            = '0;
          r.kind       = KIND_FIRE;
          r.task_index = 6'(i);
          r.time_now   = after;
          pending_events.push_back(r);
        end
      end
      tick_now   = after;
      r          = '0;
      r.kind     = KIND_DONE;
      r.time_now = after;
      r.last     = 1'b1;
      pending_events.push_back(r);
    end
  endtask

  task automatic check_event(res_t got);
    res_t want;
    if (pending_events.size() == 0) begin
      $error("unexpected result: kind %0d index %0d time %0d",
             got.kind, got.task_index, got.time_now);
      fail_count++;
      return;
    end
    want = pending_events.pop_front();
    if (got.kind !== want.kind) begin
      $error("kind: expected %0d, got %0d", want.kind, got.kind);
      fail_count++;
    end
    if (got.task_index !== want.task_index) begin
      $error("task_index: expected %0d, got %0d", want.task_index, got.task_index);
      fail_count++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      fail_count++;
    end
    if (got.time_now !== want.time_now) begin
      $error("time_now: expected %0d, got %0d", want.time_now, got.time_now);
      fail_count++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, got.last);
      fail_count++;
    end
  endtask

  // Results first: a result never belongs to the command accepted at the same edge
  always @(posedge clk) begin
    if (rst) begin
      clear_table();
      fail_count = 0;
    end else begin
      if (res_strobe) check_event(res);
      if (start && !busy) advance_schedule(cmd);
    end
    open_count = pending_events.size();
  end

endmodule

### tb/tb_periodic_task_tick_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_periodic_task_tick_scheduler_unit: top-level test of the tick scheduler
// Fills the task table with directed periods, checks the full answer, then
// sends bursts of random ticks and adds; a scoreboard predicts and checks.
// ----------------------------------------------------------------------------
module tb_periodic_task_tick_scheduler_unit;
  import ptts_pkg::*;

  localparam int unsigned TASK_SLOTS   = 8;
  localparam int unsigned RANDOM_CMDS  = 440;
  localparam int unsigned DRAIN_CYCLES = TASK_SLOTS + 6;

  logic        clk;
  logic        rst;
  logic        start;
  cmd_t        cmd;
  logic        busy;
  logic        res_strobe;
  res_t        res;
  int unsigned fail_count;
  int unsigned open_count;

  periodic_task_tick_scheduler_unit #(
    .TASK_SLOTS(TASK_SLOTS)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .busy      (busy),
    .res_strobe(res_strobe),
    .res       (res)
  );

  ptts_scoreboard #(
    .TASK_SLOTS(TASK_SLOTS)
  ) scoreboard (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .res_strobe(res_strobe),
    .res       (res),
    .fail_count(fail_count),
    .open_count(open_count)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Watchdog: worst case is ~450 ticks of 8 fires each plus gaps, far below this
  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

  // Present one command from a falling edge and hold it until the block takes it.
  // busy is stable between edges, so its value just after the falling edge is
  // what the next rising edge sees. Returns on the falling edge after acceptance,
  // leaving start high; the caller decides whether another transaction follows.
  task automatic issue_cmd(logic func, logic [15:0] period);
    start    <= 1'b1;
    cmd      <= '{func: func, period: period};
    #1;
    while (busy) begin
      @(negedge clk);
      #1;
    end
    @(negedge clk);
  endtask

  task automatic idle_for(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Hold off until every predicted result has been strobed out
  task automatic drain_results();
    start <= 1'b0;
    @(negedge clk);
    while (open_count != 0) @(negedge clk);
  endtask

  int unsigned burst_left;
  int unsigned wait_cycles;

  initial begin
    rst   = 1'b1;
    start = 1'b0;
    cmd   = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // --- directed part ---
    // Zero period: deadline equals current time, slot 0 fires from the second
    // tick onward and then on every tick.
    issue_cmd(FUNC_ADD, 16'd0);
    issue_cmd(FUNC_TICK, 16'd0);
    issue_cmd(FUNC_TICK, 16'd0);
    issue_cmd(FUNC_TICK, 16'd0);
    // Largest period never comes due within this run
    issue_cmd(FUNC_ADD, 16'hFFFF);
    issue_cmd(FUNC_ADD, 16'd1);
    issue_cmd(FUNC_TICK, 16'hFFFF);
    issue_cmd(FUNC_TICK, 16'd0);
    issue_cmd(FUNC_ADD, 16'd2);
    issue_cmd(FUNC_ADD, 16'd3);
    issue_cmd(FUNC_TICK, 16'd0);
    issue_cmd(FUNC_TICK, 16'd0);
    issue_cmd(FUNC_TICK, 16'd0);
    issue_cmd(FUNC_ADD, 16'hAAAA);
    issue_cmd(FUNC_ADD, 16'($urandom_range(0, 6)));
    issue_cmd(FUNC_ADD, 16'($urandom_range(0, 12)));
    // Table full: answer with status full, index 0, nothing changes
    issue_cmd(FUNC_ADD, 16'hFFFF);
    issue_cmd(FUNC_ADD, 16'h0000);
    issue_cmd(FUNC_TICK, 16'h5555);
    issue_cmd(FUNC_TICK, 16'd0);
    issue_cmd(FUNC_TICK, 16'd0);
    drain_results();

    // --- random part ---
    // Mostly ticks (fires come from the now-full table); adds all hit the full
    // case but still sweep every period bit. Bursts of back-to-back commands,
    // random gaps so idle cycles land on every step of a tick scan.
    burst_left = 0;
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        if (n % 97 == 50) begin
          drain_results();
        end else if ($urandom_range(0, 3) != 0) begin
          wait_cycles = $urandom_range(1, 14);
          idle_for(wait_cycles);
        end
      end
      burst_left--;
      if ($urandom_range(0, 99) < 18) begin
        issue_cmd(FUNC_ADD, 16'($urandom));
      end else begin
        issue_cmd(FUNC_TICK, 16'($urandom));
      end
    end
    start <= 1'b0;

    // --- wind down ---
    begin : wind_down
      int unsigned guard;
      guard = 0;
      while (open_count != 0 && guard < 10_000) begin
        @(negedge clk);
        guard++;
      end
    end
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0 && open_count == 0) begin
      $display("tb: success");
    end else begin
      if (open_count != 0) $error("%0d expected results never arrived", open_count);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### periodic_task_tick_scheduler_unit.f
hw/rtl/ptts_pkg.sv
hw/rtl/ptts_cell.sv
hw/rtl/periodic_task_tick_scheduler_unit.sv
tb/ptts_scoreboard.sv
tb/tb_periodic_task_tick_scheduler_unit.sv
